FILE: sv/move_to_front_recency_list_core_macros.svh
// Assertion macros used by the move-to-front recency list datapath.
`ifndef MOVE_TO_FRONT_RECENCY_LIST_CORE_MACROS_SVH
`define MOVE_TO_FRONT_RECENCY_LIST_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MTF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define MTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mtf_pkg.sv
// Types and constants of the move-to-front recency list.
package mtf_pkg;

    localparam int VALUE_W        = 6;
    localparam int MAX_VALUES_DEF = 32;

    localparam logic [VALUE_W-1:0] VALUE_COUNT_RST = 6'd32;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    typedef struct packed {
        logic               command;
        logic [VALUE_W-1:0] access_value;
    } mtf_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] out_value;
        logic               last;
    } mtf_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_DUMP_STACK,
        ST_DUMP_TAIL,
        ST_FLUSH
    } mtf_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic apply_access;
        logic stack_step;
        logic tail_step;
        logic flush;
    } mtf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic stack_empty;
        logic rot_last;
        logic tail_none;
        logic tail_last;
        logic out_free;
        logic pend_valid;
    } mtf_stat_t;

endpackage

FILE: sv/mtf_ctrl.sv
// Sequencing state machine of the move-to-front recency list.
module mtf_ctrl import mtf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_command,
    output logic      s_ready,
    input  mtf_stat_t stat,
    output mtf_cmd_t  cmd
);

    mtf_state_t state_reg;
    mtf_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_command == CMD_DUMP) ? ST_DUMP_STACK : ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                cmd.apply_access = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_DUMP_STACK: begin
                if (stat.stack_empty) begin
                    state_next = ST_DUMP_TAIL;
                end else if (stat.out_free) begin
                    cmd.stack_step = 1'b1;
                    if (stat.rot_last) begin
                        state_next = ST_DUMP_TAIL;
                    end
                end
            end
            ST_DUMP_TAIL: begin
                if (stat.tail_none) begin
                    state_next = ST_FLUSH;
                end else if (stat.out_free) begin
                    cmd.tail_step = 1'b1;
                    if (stat.tail_last) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!stat.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mtf_datapath.sv
// Stack cells, presence map, dump counters and output register of the recency list.
`include "move_to_front_recency_list_core_macros.svh"
module mtf_datapath import mtf_pkg::*; #(
    parameter int MAX_VALUES = MAX_VALUES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [VALUE_W-1:0] cfg_wr_data,
    input  logic [VALUE_W-1:0] s_access_value,
    output logic               m_valid,
    input  logic               m_ready,
    output mtf_out_t           m_data,
    input  mtf_cmd_t           cmd,
    output mtf_stat_t          stat
);

    localparam int CNT_W  = $clog2(MAX_VALUES + 1);
    localparam int PIDX_W = $clog2(MAX_VALUES);

    logic [VALUE_W-1:0]    value_count_reg;
    logic [VALUE_W-1:0]    stack_reg [MAX_VALUES];
    logic [VALUE_W-1:0]    stack_next [MAX_VALUES];
    logic [CNT_W-1:0]      stack_count_reg, stack_count_next;
    logic [MAX_VALUES-1:0] present_reg, present_next;

    // access lookup results, captured on the input transfer
    logic [VALUE_W-1:0]    val_reg;
    logic [PIDX_W-1:0]     pos_reg, pos_next;
    logic                  hit_reg, hit_next;
    logic                  range_ok_reg, range_ok_next;

    logic [PIDX_W-1:0]     dump_idx_reg;
    logic [VALUE_W-1:0]    tail_reg;
    logic                  pend_valid_reg;
    logic [VALUE_W-1:0]    pend_value_reg;
    logic                  out_valid_reg;
    mtf_out_t              out_data_reg;

    logic [VALUE_W:0]      n_wide;
    logic [VALUE_W-1:0]    n_eff;
    logic [MAX_VALUES-1:0] match;
    logic [CNT_W-1:0]      count_m1;
    logic [CNT_W-1:0]      shift_lim;
    logic                  stack_full;
    logic                  access_ok;
    logic                  tail_miss;
    logic                  emit;
    logic [VALUE_W-1:0]    cand;
    logic                  out_free;
    logic                  flush_go;
    logic                  dump_step;

    // a register above the parameter acts as the parameter
    assign n_wide = ({1'b0, value_count_reg} > (VALUE_W + 1)'(MAX_VALUES))
                    ? (VALUE_W + 1)'(MAX_VALUES) : {1'b0, value_count_reg};
    assign n_eff  = n_wide[VALUE_W-1:0];

    assign count_m1   = stack_count_reg - CNT_W'(1);
    assign stack_full = (stack_count_reg == CNT_W'(MAX_VALUES));
    assign shift_lim  = hit_reg ? CNT_W'(pos_reg) : stack_count_reg;
    assign access_ok  = range_ok_reg && (hit_reg || !stack_full);
    assign tail_miss  = !present_reg[PIDX_W'(tail_reg - VALUE_W'(1))];
    assign out_free   = !out_valid_reg || m_ready;
    assign emit       = cmd.stack_step || (cmd.tail_step && tail_miss);
    assign cand       = cmd.stack_step ? stack_reg[0] : tail_reg;
    assign flush_go   = cmd.flush && pend_valid_reg && out_free;
    assign dump_step  = cmd.stack_step || cmd.tail_step;

    // parallel compare of the incoming value against every live cell
    always_comb begin
        pos_next = '0;
        for (int i = 0; i < MAX_VALUES; i++) begin
            match[i] = (CNT_W'(i) < stack_count_reg) && (stack_reg[i] == s_access_value);
            if (match[i]) begin
                pos_next = pos_next | PIDX_W'(i);
            end
        end
        hit_next      = |match;
        range_ok_next = (s_access_value != '0) && (s_access_value <= n_eff);
    end

    // cell update: move-to-front shift on access, rotation during the dump
    always_comb begin
        stack_next       = stack_reg;
        stack_count_next = stack_count_reg;
        present_next     = present_reg;
        if (cmd.apply_access && access_ok) begin
            for (int i = 1; i < MAX_VALUES; i++) begin
                if (CNT_W'(i) <= shift_lim) begin
                    stack_next[i] = stack_reg[i-1];
                end
            end
            stack_next[0] = val_reg;
            if (!hit_reg) begin
                stack_count_next = stack_count_reg + CNT_W'(1);
                present_next[PIDX_W'(val_reg - VALUE_W'(1))] = 1'b1;
            end
        end else if (cmd.stack_step) begin
            for (int i = 0; i < MAX_VALUES; i++) begin
                if (CNT_W'(i) == count_m1) begin
                    stack_next[i] = stack_reg[0];
                end else if (CNT_W'(i) < count_m1) begin
                    stack_next[i] = stack_reg[(i == MAX_VALUES - 1) ? i : i + 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        stack_reg <= stack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_count_reg <= VALUE_COUNT_RST;
            stack_count_reg <= '0;
            present_reg     <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                value_count_reg <= cfg_wr_data;
            end
            stack_count_reg <= stack_count_next;
            present_reg     <= present_next;

            if (cmd.accept) begin
                pend_valid_reg <= 1'b0;
            end else if (flush_go) begin
                pend_valid_reg <= 1'b0;
            end else if (emit) begin
                pend_valid_reg <= 1'b1;
            end

            // the held value goes out once a later value exists or the dump ends
            if (flush_go || (emit && pend_valid_reg)) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            val_reg      <= s_access_value;
            pos_reg      <= pos_next;
            hit_reg      <= hit_next;
            range_ok_reg <= range_ok_next;
            dump_idx_reg <= '0;
            tail_reg     <= VALUE_W'(1);
        end
        if (cmd.stack_step) begin
            dump_idx_reg <= dump_idx_reg + PIDX_W'(1);
        end
        if (cmd.tail_step) begin
            tail_reg <= tail_reg + VALUE_W'(1);
        end
        if (flush_go) begin
            out_data_reg.out_value <= pend_value_reg;
            out_data_reg.last      <= 1'b1;
        end else if (emit) begin
            if (pend_valid_reg) begin
                out_data_reg.out_value <= pend_value_reg;
                out_data_reg.last      <= 1'b0;
            end
            pend_value_reg <= cand;
        end
    end

    assign stat.stack_empty = (stack_count_reg == '0);
    assign stat.rot_last    = (CNT_W'(dump_idx_reg) == count_m1);
    assign stat.tail_none   = (n_eff == '0);
    assign stat.tail_last   = (tail_reg == n_eff);
    assign stat.out_free    = out_free;
    assign stat.pend_valid  = pend_valid_reg;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `MTF_ASSERT(a_count_bound, stack_count_reg <= CNT_W'(MAX_VALUES), "stack count overflow")
    `MTF_ASSERT(a_map_count, CNT_W'($countones(present_reg)) == stack_count_reg, "map vs count")
    `MTF_ASSERT_NEXT(a_dump_ro, dump_step, $stable(present_reg), "dump changed the stack")
    `MTF_ASSERT_NEXT(a_flush_drains, flush_go, m_valid && m_data.last, "no final transfer")

endmodule

FILE: sv/move_to_front_recency_list_core.sv
// Top level of the move-to-front recency list: controller plus datapath.
// Keeps a recency-ordered stack of distinct values 1..n (n = value_count, capped at
// MAX_VALUES). An access compares its value against all stack cells in the transfer
// cycle and shifts the cells in the next; values of 0 or above n are dropped. A dump
// rotates the stack cells once through the output, then scans 1..n against the presence
// map one value per cycle while the output is free; it holds the block from its transfer
// through the stack, tail and flush states, and output stalls hold it longer. One result
// is held back so the final one carries last. Input is accepted only between items.
// value_count is written through cfg_wr_en/cfg_wr_data; the user must do so only while
// no item is in flight, as the block itself does not enforce it.
module move_to_front_recency_list_core import mtf_pkg::*; #(
    parameter int MAX_VALUES = MAX_VALUES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [VALUE_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  mtf_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mtf_out_t           m_data
);

    mtf_cmd_t  cmd;
    mtf_stat_t stat;

    mtf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_data.command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mtf_datapath #(
        .MAX_VALUES (MAX_VALUES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_access_value (s_data.access_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule
